>>> sv/nfc_pkg.sv
// ----------------------------------------------------------------------------
// nfc_pkg
// Types and constants shared by the flow cache modules.
// ----------------------------------------------------------------------------
`default_nettype none
package nfc_pkg;

  localparam logic [1:0] ACT_PACKET = 2'd0;
  localparam logic [1:0] ACT_SCAN   = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;

  localparam logic [1:0] REG_CACHE_LIMIT = 2'd0;
  localparam logic [1:0] REG_ACTIVE_TO   = 2'd1;
  localparam logic [1:0] REG_INACTIVE_TO = 2'd2;

  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [31:0] ETH_HEADER = 32'd14;
  localparam logic [9:0]  MS_PER_S   = 10'd1000;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_EV,
    S_LAST,
    S_PK,
    S_PKNEW
  } state_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
  } flow_key_t;

  typedef struct packed {
    logic        valid;
    flow_key_t   key;
    logic [31:0] packets;
    logic [31:0] octets;
    logic [31:0] first_ms;
    logic [31:0] last_ms;
    logic [7:0]  flags_seen;
    logic [7:0]  flags_prev;
    logic [7:0]  tos;
  } flow_entry_t;

endpackage : nfc_pkg
`default_nettype wire

>>> sv/nfc_ram.sv
// ----------------------------------------------------------------------------
// nfc_ram
// Single-write, single-read flow table with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module nfc_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire [AW-1:0]             wr_addr,
  input  wire nfc_pkg::flow_entry_t wr_data,
  input  wire                      rd_en,
  input  wire [AW-1:0]             rd_addr,
  output nfc_pkg::flow_entry_t     rd_data
);
  import nfc_pkg::*;

  flow_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : nfc_ram
`default_nettype wire

>>> sv/netflow_v5_flow_cache_top.sv
// ----------------------------------------------------------------------------
// netflow_v5_flow_cache_top
// NetFlow v5 flow cache: packet update, eviction, timeout scan and flush.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_* (valid/stall), exported flow records leave on
// out_* (valid/stall), registers are written on cfg_* (valid/ready, always
// ready). in_stall is high whenever the block is busy with an item.
// Every packet, scan or flush item walks the whole flow table, one slot at a
// time, with a read state and then an evaluate state per slot through the
// single table read port; a scan or flush that reaches BATCH_MAX records ends
// its walk early, and a packet that evicts writes the new flow in a further
// state after the evicted slot. Records sit in a pending register and then
// one output register, so a stalled receiver only holds the walk when a
// further record is found while both are full.
// end_of_run marks the last record of an item; a packet gives at most one.
// After reset the table is cleared one slot per cycle, during which no item
// is taken; registers reset to limit 1024, active timeout 60 s and inactive
// timeout 10 s.
// ----------------------------------------------------------------------------
`default_nettype none
module netflow_v5_flow_cache_top #(
  parameter int CAPACITY  = 1024,
  parameter int BATCH_MAX = 30
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_action,
  input  wire  [31:0] in_src_addr,
  input  wire  [31:0] in_dst_addr,
  input  wire  [15:0] in_src_port,
  input  wire  [15:0] in_dst_port,
  input  wire  [7:0]  in_ip_protocol,
  input  wire  [7:0]  in_type_of_service,
  input  wire  [7:0]  in_packet_tcp_flags,
  input  wire  [15:0] in_frame_length,
  input  wire  [31:0] in_time_ms,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_src_addr,
  output logic [31:0] out_dst_addr,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  output logic [7:0]  out_protocol,
  output logic [7:0]  out_tos,
  output logic [7:0]  out_flags_seen,
  output logic [31:0] out_packets,
  output logic [31:0] out_octets,
  output logic [31:0] out_first_ms,
  output logic [31:0] out_last_ms,
  output logic        out_end_of_run,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  import nfc_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCW  = $clog2(CAPACITY + 1);
  localparam int NW   = $clog2(BATCH_MAX + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

  state_t state_r, state_nxt;

  logic [AW-1:0]  idx_r, idx_nxt;
  logic [OCW-1:0] occ_r, occ_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;
  logic [10:0]    limit_r;
  logic [15:0]    act_to_r, inact_to_r;

  logic [1:0]   act_r;
  flow_key_t    key_r;
  logic [7:0]   tos_r, flags_r;
  logic [31:0]  l3_r, now_r, ilim_r, alim_r;

  logic         hit_r, hit_nxt, free_r, free_nxt, old_r, old_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic [AW-1:0] old_idx_r, old_idx_nxt, new_idx_r, new_idx_nxt;
  flow_entry_t  hit_ent_r, hit_ent_nxt, old_ent_r, old_ent_nxt;
  logic         pend_r, pend_nxt;
  flow_entry_t  pend_ent_r, pend_ent_nxt;

  logic         out_valid_r, out_valid_nxt, out_eor_r, out_eor_nxt;
  flow_entry_t  out_ent_r, out_ent_nxt;

  logic         wr_en, rd_en;
  logic [AW-1:0] wr_addr;
  flow_entry_t  wr_data, rd_data;

  logic         accept, out_free, last_slot, match, term, evict;
  flow_entry_t  upd_ent, new_ent;
  logic [31:0]  lim_c;

  nfc_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_slot = (idx_r == LAST_IDX);
  assign rd_en     = (state_r == S_RD);

  always_comb begin
    if (limit_r == 11'd0) begin
      lim_c = 32'd1;
    end else if (32'(limit_r) > 32'(CAPACITY)) begin
      lim_c = 32'(CAPACITY);
    end else begin
      lim_c = 32'(limit_r);
    end
  end

  assign evict = (32'(occ_r) >= lim_c) && old_r;

  // scan/flush candidate in the slot just read
  assign match = rd_data.valid &&
                 ((act_r == ACT_FLUSH) ||
                  ((now_r - rd_data.last_ms) > ilim_r) ||
                  ((rd_data.last_ms - rd_data.first_ms) > alim_r));

  always_comb begin
    upd_ent            = hit_ent_r;
    upd_ent.packets    = hit_ent_r.packets + 32'd1;
    upd_ent.octets     = hit_ent_r.octets + l3_r;
    upd_ent.last_ms    = now_r;
    upd_ent.flags_seen = hit_ent_r.flags_seen | flags_r;
    upd_ent.flags_prev = flags_r;
    term = (flags_r[0] && hit_ent_r.flags_prev[4]) ||
           (flags_r[4] && hit_ent_r.flags_prev[0]);
    new_ent            = '{valid: 1'b1, key: key_r, packets: 32'd1, octets: l3_r,
                           first_ms: now_r, last_ms: now_r, flags_seen: flags_r,
                           flags_prev: flags_r, tos: tos_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:   if (last_slot) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept && (in_action == ACT_PACKET || in_action == ACT_SCAN ||
                       in_action == ACT_FLUSH)) begin
          state_nxt = S_RD;
        end
      end
      S_RD:    state_nxt = S_EV;
      S_EV: begin
        if (act_r == ACT_PACKET) begin
          state_nxt = last_slot ? S_PK : S_RD;
        end else if (!(match && pend_r && !out_free)) begin
          if ((match && (cnt_r + NW'(1) == NW'(BATCH_MAX))) || last_slot) begin
            state_nxt = S_LAST;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_LAST:  if (!pend_r || out_free) state_nxt = S_IDLE;
      S_PK: begin
        if (hit_r) begin
          if (!term || out_free) state_nxt = S_IDLE;
        end else if (evict) begin
          if (out_free) state_nxt = S_PKNEW;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PKNEW: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and table writes
  always_comb begin
    idx_nxt       = idx_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_ent_nxt   = hit_ent_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    old_nxt       = old_r;
    old_idx_nxt   = old_idx_r;
    old_ent_nxt   = old_ent_r;
    new_idx_nxt   = new_idx_r;
    pend_nxt      = pend_r;
    pend_ent_nxt  = pend_ent_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ent_nxt   = out_ent_r;
    out_eor_nxt   = out_eor_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = '0;

    unique case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        idx_nxt = idx_r + AW'(1);
      end
      S_IDLE: begin
        idx_nxt  = '0;
        cnt_nxt  = '0;
        hit_nxt  = 1'b0;
        free_nxt = 1'b0;
        old_nxt  = 1'b0;
        pend_nxt = 1'b0;
      end
      S_EV: begin
        if (act_r == ACT_PACKET) begin
          if (rd_data.valid && rd_data.key == key_r && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = idx_r;
            hit_ent_nxt = rd_data;
          end
          if (!rd_data.valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = idx_r;
          end
          // strict compare keeps the lowest slot among equal first times
          if (rd_data.valid && (!old_r || rd_data.first_ms < old_ent_r.first_ms)) begin
            old_nxt     = 1'b1;
            old_idx_nxt = idx_r;
            old_ent_nxt = rd_data;
          end
          idx_nxt = idx_r + AW'(1);
        end else if (!(match && pend_r && !out_free)) begin
          if (match) begin
            wr_en        = 1'b1;
            wr_data      = rd_data;
            wr_data.valid = 1'b0;
            occ_nxt      = occ_r - OCW'(1);
            cnt_nxt      = cnt_r + NW'(1);
            pend_nxt     = 1'b1;
            pend_ent_nxt = rd_data;
            if (pend_r) begin
              out_valid_nxt = 1'b1;
              out_ent_nxt   = pend_ent_r;
              out_eor_nxt   = 1'b0;
            end
          end
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_LAST: begin
        if (pend_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_ent_nxt   = pend_ent_r;
          out_eor_nxt   = 1'b1;
          pend_nxt      = 1'b0;
        end
      end
      S_PK: begin
        if (hit_r) begin
          if (!term) begin
            wr_en   = 1'b1;
            wr_addr = hit_idx_r;
            wr_data = upd_ent;
          end else if (out_free) begin
            wr_en         = 1'b1;
            wr_addr       = hit_idx_r;
            wr_data       = upd_ent;
            wr_data.valid = 1'b0;
            occ_nxt       = occ_r - OCW'(1);
            out_valid_nxt = 1'b1;
            out_ent_nxt   = upd_ent;
            out_eor_nxt   = 1'b1;
          end
        end else if (evict) begin
          if (out_free) begin
            wr_en         = 1'b1;
            wr_addr       = old_idx_r;
            wr_data       = old_ent_r;
            wr_data.valid = 1'b0;
            occ_nxt       = occ_r - OCW'(1);
            out_valid_nxt = 1'b1;
            out_ent_nxt   = old_ent_r;
            out_eor_nxt   = 1'b1;
            new_idx_nxt   = (free_r && free_idx_r < old_idx_r) ? free_idx_r : old_idx_r;
          end
        end else if (free_r) begin
          wr_en   = 1'b1;
          wr_addr = free_idx_r;
          wr_data = new_ent;
          occ_nxt = occ_r + OCW'(1);
        end
      end
      S_PKNEW: begin
        wr_en   = 1'b1;
        wr_addr = new_idx_r;
        wr_data = new_ent;
        occ_nxt = occ_r + OCW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      occ_r       <= '0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      old_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= 11'd1024;
      act_to_r    <= 16'd60;
      inact_to_r  <= 16'd10;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      old_r       <= old_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CACHE_LIMIT: limit_r    <= cfg_data[10:0];
          REG_ACTIVE_TO:   act_to_r   <= cfg_data;
          REG_INACTIVE_TO: inact_to_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    hit_ent_r  <= hit_ent_nxt;
    free_idx_r <= free_idx_nxt;
    old_idx_r  <= old_idx_nxt;
    old_ent_r  <= old_ent_nxt;
    new_idx_r  <= new_idx_nxt;
    pend_ent_r <= pend_ent_nxt;
    out_ent_r  <= out_ent_nxt;
    out_eor_r  <= out_eor_nxt;
    if (accept) begin
      act_r          <= in_action;
      key_r.src_addr <= in_src_addr;
      key_r.dst_addr <= in_dst_addr;
      key_r.src_port <= in_src_port;
      key_r.dst_port <= in_dst_port;
      key_r.protocol <= in_ip_protocol;
      tos_r          <= in_type_of_service;
      flags_r        <= (in_ip_protocol == PROTO_TCP) ? in_packet_tcp_flags : 8'd0;
      l3_r           <= 32'(in_frame_length) - ETH_HEADER;
      now_r          <= in_time_ms;
      // timeouts in ms; 32 bits hold the largest product without wrapping
      ilim_r         <= 32'(inact_to_r) * 32'(MS_PER_S);
      alim_r         <= 32'(act_to_r) * 32'(MS_PER_S);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_src_addr   = out_ent_r.key.src_addr;
  assign out_dst_addr   = out_ent_r.key.dst_addr;
  assign out_src_port   = out_ent_r.key.src_port;
  assign out_dst_port   = out_ent_r.key.dst_port;
  assign out_protocol   = out_ent_r.key.protocol;
  assign out_tos        = out_ent_r.tos;
  assign out_flags_seen = out_ent_r.flags_seen;
  assign out_packets    = out_ent_r.packets;
  assign out_octets     = out_ent_r.octets;
  assign out_first_ms   = out_ent_r.first_ms;
  assign out_last_ms    = out_ent_r.last_ms;
  assign out_end_of_run = out_eor_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) <= 32'(CAPACITY))
    else $error("flow count above capacity");

  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall)
    else $error("item taken during table clear");

  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_RD || state_r == S_EV || state_r == S_LAST))
    else $error("pending record outside a scan");

  a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(BATCH_MAX))
    else $error("batch count above limit");
`endif

endmodule : netflow_v5_flow_cache_top
`default_nettype wire
